FILE: hdl/hgp_pkg.sv
package hgp_pkg;

    // config register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 2'd1;

    localparam int QUO_BITS = 8;
    localparam int CHAN_BITS = 8;

    // hue regions across the palette width, left to right
    typedef enum logic [2:0] {
        HUE_RED_GREEN_UP    = 3'd0,
        HUE_GREEN_RED_DOWN  = 3'd1,
        HUE_GREEN_BLUE_UP   = 3'd2,
        HUE_BLUE_GREEN_DOWN = 3'd3,
        HUE_BLUE_RED_UP     = 3'd4,
        HUE_RED_BLUE_DOWN   = 3'd5
    } hue_region_t;

endpackage

FILE: hdl/hue_gradient_palette_pixel.sv
// channel  | handshake            | payload
// ---------+----------------------+------------------------------------------
// config   | cfg_valid/cfg_ready  | cfg_index, cfg_data (width / height)
// pixel in | s_valid/s_ready      | s_pixel_x, s_pixel_y
// color out| m_valid/m_ready      | m_red, m_green, m_blue
//
// One pixel beat per clock sustained while m_ready is high. The pipe holds two
// front stages (clamp, hue region), an 8-stage divider for the blue ramp, two
// blend stages and one 8-stage divider, a lane per channel, for the grey blend.
// Reset restores width and height to 256 (2**COORD_BITS if smaller); cfg_ready is always high.
// Each stage moves on when its successor has room, so a stall on m_ready
// fills bubbles first and only then backs up to s_ready.
module hue_gradient_palette_pixel #(
    parameter int COORD_BITS = 12
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hgp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [COORD_BITS:0]               cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [COORD_BITS-1:0]             s_pixel_x,
    input  logic [COORD_BITS-1:0]             s_pixel_y,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [hgp_pkg::CHAN_BITS-1:0]     m_red,
    output logic [hgp_pkg::CHAN_BITS-1:0]     m_green,
    output logic [hgp_pkg::CHAN_BITS-1:0]     m_blue
);
    import hgp_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int WB  = CB + 1;
    localparam int SB  = CB + 3;
    localparam int AB  = CB + 8;
    localparam int PB  = 2 * CB + 1;
    localparam int NB  = 2 * CB + 8;
    localparam int MB  = 2 * CB + 9;
    localparam int PW1 = 3 + CB + PB + PB + WB;
    localparam int RST_SIZE = (CB >= 8) ? 256 : (1 << CB);
    localparam logic [WB-1:0] SIZE_MAX = WB'(1) << CB;

    // ---------------- configuration ----------------
    logic [WB-1:0] width_reg, height_reg;
    logic [WB-1:0] w_eff, h_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WB'(RST_SIZE);
            height_reg <= WB'(RST_SIZE);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (width_reg == '0)          w_eff = WB'(1);
        else if (width_reg > SIZE_MAX) w_eff = SIZE_MAX;
        else                           w_eff = width_reg;
        if (height_reg == '0)          h_eff = WB'(1);
        else if (height_reg > SIZE_MAX) h_eff = SIZE_MAX;
        else                            h_eff = height_reg;
    end

    // ---------------- handshake chain ----------------
    logic f0_v_reg, f1_v_reg, m0_v_reg, m1_v_reg;
    logic adv_f0, adv_f1, adv_m0, adv_m1;
    logic d1_in_ready, d1_out_valid, d2_in_ready;

    assign adv_m1  = !m1_v_reg || d2_in_ready;
    assign adv_m0  = !m0_v_reg || adv_m1;
    assign adv_f1  = !f1_v_reg || d1_in_ready;
    assign adv_f0  = !f0_v_reg || adv_f1;
    assign s_ready = adv_f0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f0_v_reg <= 1'b0;
            f1_v_reg <= 1'b0;
            m0_v_reg <= 1'b0;
            m1_v_reg <= 1'b0;
        end else begin
            if (adv_f0) f0_v_reg <= s_valid;
            if (adv_f1) f1_v_reg <= f0_v_reg;
            if (adv_m0) m0_v_reg <= d1_out_valid;
            if (adv_m1) m1_v_reg <= m0_v_reg;
        end
    end

    // ---------------- F0: clamp, 6x ----------------
    logic [CB-1:0] x_cl, y_cl;
    logic [CB-1:0] f0_x_reg, f0_y_reg;
    logic [SB-1:0] f0_six_reg;

    always_comb begin
        x_cl = (WB'(s_pixel_x) > w_eff - WB'(1)) ? CB'(w_eff - WB'(1)) : s_pixel_x;
        y_cl = (WB'(s_pixel_y) > h_eff - WB'(1)) ? CB'(h_eff - WB'(1)) : s_pixel_y;
    end

    always_ff @(posedge aclk) begin
        if (adv_f0) begin
            f0_x_reg   <= x_cl;
            f0_y_reg   <= y_cl;
            f0_six_reg <= (SB'(x_cl) << 2) + (SB'(x_cl) << 1);
        end
    end

    // ---------------- F1: hue region, offset, products ----------------
    logic [SB-1:0] mult [6];
    logic [2:0]    k_next;
    logic [CB-1:0] n_next;
    logic [2:0]    f1_k_reg;
    logic [CB-1:0] f1_n_reg;
    logic [PB-1:0] f1_yw_reg, f1_wh_reg;
    logic [WB-1:0] f1_hy_reg;

    always_comb begin
        for (int j = 0; j < 6; j++) begin
            mult[j] = SB'(w_eff) * SB'(j);
        end
        k_next = '0;
        for (int j = 1; j < 6; j++) begin
            if (f0_six_reg >= mult[j]) k_next = k_next + 3'd1;
        end
        n_next = CB'(f0_six_reg - mult[k_next]);
    end

    always_ff @(posedge aclk) begin
        if (adv_f1) begin
            f1_k_reg  <= k_next;
            f1_n_reg  <= n_next;
            f1_yw_reg <= PB'(f0_y_reg) * PB'(w_eff);
            f1_wh_reg <= PB'(w_eff) * PB'(h_eff);
            f1_hy_reg <= h_eff - WB'(f0_y_reg);
        end
    end

    // ---------------- blue ramp truncation: floor(255n / w) ----------------
    logic [0:0][AB-1:0]        d1_num;
    logic [0:0][QUO_BITS-1:0]  d1_quo;
    logic [PW1-1:0]            d1_pay;
    logic [2:0]                d1_k;
    logic [CB-1:0]             d1_n;
    logic [PB-1:0]             d1_yw, d1_wh;
    logic [WB-1:0]             d1_hy;

    assign d1_num[0] = (AB'(f1_n_reg) << 8) - AB'(f1_n_reg);

    hgp_div #(
        .NB    (AB),
        .DB    (WB),
        .LANES (1),
        .PW    (PW1)
    ) u_div_ramp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f1_v_reg),
        .in_ready  (d1_in_ready),
        .in_num    (d1_num),
        .in_den    (w_eff),
        .in_pay    ({f1_k_reg, f1_n_reg, f1_yw_reg, f1_wh_reg, f1_hy_reg}),
        .out_valid (d1_out_valid),
        .out_ready (adv_m0),
        .out_quo   (d1_quo),
        .out_pay   (d1_pay)
    );

    assign {d1_k, d1_n, d1_yw, d1_wh, d1_hy} = d1_pay;

    // ---------------- M0: channel numerators over w ----------------
    logic [AB-1:0] top, up, down, bq;
    logic [AB-1:0] ar_next, ag_next, ab_next;
    logic [AB-1:0] m0_ar_reg, m0_ag_reg, m0_ab_reg;
    logic [NB-1:0] m0_g_reg;
    logic [WB-1:0] m0_hy_reg;
    logic [PB-1:0] m0_wh_reg;

    always_comb begin
        top  = (AB'(w_eff) << 8) - AB'(w_eff);
        up   = (AB'(d1_n) << 8) - AB'(d1_n);
        down = top - up;
        bq   = AB'(d1_quo[0]) * AB'(w_eff);
        case (hue_region_t'(d1_k))
            HUE_RED_GREEN_UP: begin
                ar_next = top;  ag_next = up;   ab_next = '0;
            end
            HUE_GREEN_RED_DOWN: begin
                ar_next = down; ag_next = top;  ab_next = '0;
            end
            HUE_GREEN_BLUE_UP: begin
                ar_next = '0;   ag_next = top;  ab_next = bq;
            end
            HUE_BLUE_GREEN_DOWN: begin
                ar_next = '0;   ag_next = down; ab_next = top;
            end
            HUE_BLUE_RED_UP: begin
                ar_next = up;   ag_next = '0;   ab_next = top;
            end
            default: begin
                ar_next = top;  ag_next = '0;   ab_next = down;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv_m0) begin
            m0_ar_reg <= ar_next;
            m0_ag_reg <= ag_next;
            m0_ab_reg <= ab_next;
            m0_g_reg  <= (NB'(d1_yw) << 7) - NB'(d1_yw);
            m0_hy_reg <= d1_hy;
            m0_wh_reg <= d1_wh;
        end
    end

    // ---------------- M1: blend numerators A*(h-y) + 127*y*w ----------------
    logic [NB-1:0] m1_nr_reg, m1_ng_reg, m1_nb_reg;
    logic [PB-1:0] m1_wh_reg;

    always_ff @(posedge aclk) begin
        if (adv_m1) begin
            m1_nr_reg <= NB'(MB'(m0_ar_reg) * MB'(m0_hy_reg)) + m0_g_reg;
            m1_ng_reg <= NB'(MB'(m0_ag_reg) * MB'(m0_hy_reg)) + m0_g_reg;
            m1_nb_reg <= NB'(MB'(m0_ab_reg) * MB'(m0_hy_reg)) + m0_g_reg;
            m1_wh_reg <= m0_wh_reg;
        end
    end

    // ---------------- grey blend divide by w*h ----------------
    logic [2:0][NB-1:0]       d2_num;
    logic [2:0][QUO_BITS-1:0] d2_quo;

    assign d2_num[0] = m1_nr_reg;
    assign d2_num[1] = m1_ng_reg;
    assign d2_num[2] = m1_nb_reg;

    hgp_div #(
        .NB    (NB),
        .DB    (PB),
        .LANES (3),
        .PW    (1)
    ) u_div_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (m1_v_reg),
        .in_ready  (d2_in_ready),
        .in_num    (d2_num),
        .in_den    (m1_wh_reg),
        .in_pay    (1'b0),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_quo   (d2_quo),
        .out_pay   ()
    );

    assign m_red   = d2_quo[0];
    assign m_green = d2_quo[1];
    assign m_blue  = d2_quo[2];

    // ---------------- assertions ----------------
    a_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        f0_v_reg |-> (WB'(f0_x_reg) < w_eff) && (WB'(f0_y_reg) < h_eff))
        else $error("clamped coordinate outside palette");

    a_region: assert property (@(posedge aclk) disable iff (!aresetn)
        f1_v_reg |-> (f1_k_reg <= HUE_RED_BLUE_DOWN) && (WB'(f1_n_reg) < w_eff))
        else $error("hue offset not below width");

    a_ramp: assert property (@(posedge aclk) disable iff (!aresetn)
        d1_out_valid |-> (d1_quo[0] != 8'hFF))
        else $error("ramp quotient out of range");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output beat valid after reset");

endmodule

FILE: hdl/hgp_div.sv
module hgp_div #(
    parameter int NB    = 32,
    parameter int DB    = 25,
    parameter int LANES = 1,
    parameter int PW    = 1
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [LANES-1:0][NB-1:0]               in_num,
    input  logic [DB-1:0]                          in_den,
    input  logic [PW-1:0]                          in_pay,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [LANES-1:0][hgp_pkg::QUO_BITS-1:0] out_quo,
    output logic [PW-1:0]                          out_pay
);
    import hgp_pkg::*;

    localparam int QB = QUO_BITS;
    localparam int RW = (NB > DB + QB) ? NB : DB + QB;

    // one quotient bit per stage, MSB first; quotient is known to fit QB bits
    logic [QB-1:0] v_reg;
    logic [QB:0]   adv;
    logic [RW-1:0] rem_reg  [QB][LANES];
    logic [QB-1:0] quo_reg  [QB][LANES];
    logic [DB-1:0] den_reg  [QB];
    logic [PW-1:0] pay_reg  [QB];

    logic [QB-1:0] v_src;
    logic [RW-1:0] rem_src  [QB][LANES];
    logic [QB-1:0] quo_src  [QB][LANES];
    logic [DB-1:0] den_src  [QB];
    logic [PW-1:0] pay_src  [QB];
    logic [RW-1:0] rem_next [QB][LANES];
    logic [QB-1:0] quo_next [QB][LANES];

    always_comb begin
        adv[QB] = out_ready;
        for (int i = QB - 1; i >= 0; i--) begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
    end

    always_comb begin
        logic [RW-1:0] dsh;
        for (int i = 0; i < QB; i++) begin
            if (i == 0) begin
                v_src[i]   = in_valid;
                den_src[i] = in_den;
                pay_src[i] = in_pay;
                for (int l = 0; l < LANES; l++) begin
                    rem_src[i][l] = RW'(in_num[l]);
                    quo_src[i][l] = '0;
                end
            end else begin
                v_src[i]   = v_reg[i-1];
                den_src[i] = den_reg[i-1];
                pay_src[i] = pay_reg[i-1];
                for (int l = 0; l < LANES; l++) begin
                    rem_src[i][l] = rem_reg[i-1][l];
                    quo_src[i][l] = quo_reg[i-1][l];
                end
            end
            dsh = RW'(den_src[i]) << (QB - 1 - i);
            for (int l = 0; l < LANES; l++) begin
                if (rem_src[i][l] >= dsh) begin
                    rem_next[i][l] = rem_src[i][l] - dsh;
                    quo_next[i][l] = quo_src[i][l] | (QB'(1) << (QB - 1 - i));
                end else begin
                    rem_next[i][l] = rem_src[i][l];
                    quo_next[i][l] = quo_src[i][l];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int i = 0; i < QB; i++) begin
                if (adv[i]) begin
                    v_reg[i] <= v_src[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QB; i++) begin
            if (adv[i]) begin
                den_reg[i] <= den_src[i];
                pay_reg[i] <= pay_src[i];
                for (int l = 0; l < LANES; l++) begin
                    rem_reg[i][l] <= rem_next[i][l];
                    quo_reg[i][l] <= quo_next[i][l];
                end
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[QB-1];
    assign out_pay   = pay_reg[QB-1];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            out_quo[l] = quo_reg[QB-1][l];
        end
    end

endmodule
